@@ src/ldsw_pkg.sv @@
// Shared types, register indexes, reset values and the glyph table for the
// two-wire LED digit writer. No dependencies.
`default_nettype none

package ldsw_pkg;

  // Configuration register indexes
  localparam int unsigned CfgAddrW = 2;
  localparam logic [CfgAddrW-1:0] REG_DATA_CMD = 2'd0;
  localparam logic [CfgAddrW-1:0] REG_ADDR_CMD = 2'd1;
  localparam logic [CfgAddrW-1:0] REG_DISP_CTL = 2'd2;

  // Register reset values
  localparam logic [7:0] DATA_CMD_RST = 8'h40;
  localparam logic [7:0] ADDR_CMD_RST = 8'hC0;
  localparam logic [7:0] DISP_CTL_RST = 8'h8F;

  // Colon segment sits in bit 7 of the second digit
  localparam logic [7:0] COLON_MASK = 8'h80;

  // Byte numbers within a frame
  localparam logic [2:0] BYTE_DATA_CMD  = 3'd0;
  localparam logic [2:0] BYTE_ADDR_CMD  = 3'd1;
  localparam logic [2:0] BYTE_DIGIT0    = 3'd2;
  localparam logic [2:0] BYTE_DIGIT1    = 3'd3;
  localparam logic [2:0] BYTE_DIGIT2    = 3'd4;
  localparam logic [2:0] BYTE_DIGIT3    = 3'd5;
  localparam logic [2:0] BYTE_DISP_CTL  = 3'd6;
  localparam logic [2:0] BYTE_END       = 3'd7;
  localparam logic [2:0] LAST_BIT       = 3'd7;

  // Pin-phase sequencer states
  typedef enum logic [7:0] {
    PH_START  = 8'b0000_0001,
    PH_BITLO  = 8'b0000_0010,
    PH_BITHI  = 8'b0000_0100,
    PH_ACKLO  = 8'b0000_1000,
    PH_ACKSMP = 8'b0001_0000,
    PH_STOP0  = 8'b0010_0000,
    PH_STOP1  = 8'b0100_0000,
    PH_STOP2  = 8'b1000_0000
  } phase_t;

  // One input transaction
  typedef struct packed {
    logic       start_frame;
    logic [7:0] hours_bcd;
    logic [7:0] minutes_bcd;
    logic       colon_on;
    logic       dio_sample;
  } in_item_t;

  // Input register contents handed to the sequencer
  typedef struct packed {
    logic     valid;
    in_item_t item;
  } stage_t;

  // Configuration register file contents
  typedef struct packed {
    logic [7:0] data_command;
    logic [7:0] address_command;
    logic [7:0] display_control;
  } cfg_regs_t;

  // Seven-segment glyph, blank for nibbles above nine
  function automatic logic [7:0] glyph(input logic [3:0] nib);
    logic [7:0] g;
    unique case (nib)
      4'd0:    g = 8'h3f;
      4'd1:    g = 8'h06;
      4'd2:    g = 8'h5b;
      4'd3:    g = 8'h4f;
      4'd4:    g = 8'h66;
      4'd5:    g = 8'h6d;
      4'd6:    g = 8'h7d;
      4'd7:    g = 8'h07;
      4'd8:    g = 8'h7f;
      4'd9:    g = 8'h6f;
      default: g = 8'h00;
    endcase
    return g;
  endfunction

endpackage

`default_nettype wire

@@ src/ldsw_ifs.sv @@
// Channel interfaces of the LED digit writer: input, result and config write.
// Depends on ldsw_pkg for the register index width.
`default_nettype none

// Input channel: one pin-phase tick per transaction
interface ldsw_in_if;
  logic       valid;
  logic       ready;
  logic       start_frame;
  logic [7:0] hours_bcd;
  logic [7:0] minutes_bcd;
  logic       colon_on;
  logic       dio_sample;

  modport source (output valid, start_frame, hours_bcd, minutes_bcd, colon_on, dio_sample,
                  input ready);
  modport sink   (input valid, start_frame, hours_bcd, minutes_bcd, colon_on, dio_sample,
                  output ready);
endinterface

// Result channel: pin levels and status after each tick
interface ldsw_out_if;
  logic valid;
  logic ready;
  logic clk_level;
  logic dio_level;
  logic busy_res;
  logic frame_done;
  logic nack_error;

  modport source (output valid, clk_level, dio_level, busy_res, frame_done, nack_error,
                  input ready);
  modport sink   (input valid, clk_level, dio_level, busy_res, frame_done, nack_error,
                  output ready);
endinterface

// Configuration write channel
interface ldsw_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [ldsw_pkg::CfgAddrW-1:0] addr;
  logic [7:0]                    data;

  modport source (output valid, addr, data, input ready);
  modport sink   (input valid, addr, data, output ready);
endinterface

`default_nettype wire

@@ src/ldsw_cfg_regs.sv @@
// Configuration register file: data command, address command, display control.
// Depends on ldsw_pkg and ldsw_cfg_if.
`default_nettype none

module ldsw_cfg_regs (
  input  wire logic          clk,
  input  wire logic          rst_n,
  ldsw_cfg_if.sink           cfg,
  output ldsw_pkg::cfg_regs_t regs
);

  ldsw_pkg::cfg_regs_t regs_r;
  ldsw_pkg::cfg_regs_t regs_nxt;

  // Writes are always taken; unknown indexes are dropped
  assign cfg.ready = 1'b1;

  always_comb begin
    regs_nxt = regs_r;
    if (cfg.valid) begin
      unique case (cfg.addr)
        ldsw_pkg::REG_DATA_CMD: regs_nxt.data_command    = cfg.data;
        ldsw_pkg::REG_ADDR_CMD: regs_nxt.address_command = cfg.data;
        ldsw_pkg::REG_DISP_CTL: regs_nxt.display_control = cfg.data;
        default:                regs_nxt = regs_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      regs_r.data_command    <= ldsw_pkg::DATA_CMD_RST;
      regs_r.address_command <= ldsw_pkg::ADDR_CMD_RST;
      regs_r.display_control <= ldsw_pkg::DISP_CTL_RST;
    end else begin
      regs_r <= regs_nxt;
    end
  end

  assign regs = regs_r;

endmodule

`default_nettype wire

@@ src/ldsw_in_stage.sv @@
// Input register of the writer: holds one accepted tick until the sequencer
// takes it. Depends on ldsw_pkg and ldsw_in_if.
`default_nettype none

module ldsw_in_stage (
  input  wire logic      clk,
  input  wire logic      rst_n,
  ldsw_in_if.sink        in_ch,
  input  wire logic      advance,
  output ldsw_pkg::stage_t stage
);

  logic               valid_r;
  logic               valid_nxt;
  ldsw_pkg::in_item_t item_r;
  logic               take;

  // Room when empty or when the held tick moves on this cycle
  assign in_ch.ready = !valid_r || advance;
  assign take        = in_ch.valid && in_ch.ready;

  always_comb begin
    valid_nxt = valid_r;
    if (take) begin
      valid_nxt = 1'b1;
    end else if (advance) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // Payload capture
  always_ff @(posedge clk) begin
    if (take) begin
      item_r.start_frame <= in_ch.start_frame;
      item_r.hours_bcd   <= in_ch.hours_bcd;
      item_r.minutes_bcd <= in_ch.minutes_bcd;
      item_r.colon_on    <= in_ch.colon_on;
      item_r.dio_sample  <= in_ch.dio_sample;
    end
  end

  assign stage.valid = valid_r;
  assign stage.item  = item_r;

endmodule

`default_nettype wire

@@ src/ldsw_frame_seq.sv @@
// Frame sequencer: pin-phase state machine, digit store and result register.
// Depends on ldsw_pkg and ldsw_out_if.
`default_nettype none

module ldsw_frame_seq (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire ldsw_pkg::stage_t    stage,
  input  wire ldsw_pkg::cfg_regs_t regs,
  output logic                     advance,
  ldsw_out_if.source               out_ch
);

  ldsw_pkg::phase_t phase_r, phase_nxt;
  logic [2:0] byte_number_r, byte_number_nxt;
  logic [2:0] bit_number_r, bit_number_nxt;
  logic [7:0] shift_byte_r, shift_byte_nxt;
  logic       clk_pin_r, clk_pin_nxt;
  logic       dio_pin_r, dio_pin_nxt;
  logic       frame_active_r, frame_active_nxt;
  logic [7:0] segment_latch_r [4];

  logic       out_valid_r, out_valid_nxt;
  logic       out_clk_r, out_dio_r, out_busy_r, out_done_r, out_nack_r;

  logic       fire;
  logic       load_digits;
  logic       done, nack;
  logic [2:0] sel_byte;
  logic [1:0] seg_idx;
  logic [7:0] sel_value;
  logic       ack;

  // Move a tick forward when the result register is free or being drained
  assign advance = !out_valid_r || out_ch.ready;
  assign fire    = stage.valid && advance;
  assign ack     = stage.item.dio_sample;

  assign load_digits = fire && !frame_active_r && stage.item.start_frame;

  // Byte source for the next transfer
  assign sel_byte = (phase_r == ldsw_pkg::PH_ACKSMP) ? byte_number_r + 3'd1 : byte_number_r;
  assign seg_idx  = sel_byte[1:0] + 2'd2;

  always_comb begin
    unique case (sel_byte)
      ldsw_pkg::BYTE_DATA_CMD:  sel_value = regs.data_command;
      ldsw_pkg::BYTE_ADDR_CMD:  sel_value = regs.address_command;
      ldsw_pkg::BYTE_DIGIT0,
      ldsw_pkg::BYTE_DIGIT1,
      ldsw_pkg::BYTE_DIGIT2,
      ldsw_pkg::BYTE_DIGIT3:    sel_value = segment_latch_r[seg_idx];
      ldsw_pkg::BYTE_DISP_CTL:  sel_value = regs.display_control;
      default:                  sel_value = 8'h00;
    endcase
  end

  // Next pin phase
  always_comb begin
    phase_nxt        = phase_r;
    byte_number_nxt  = byte_number_r;
    bit_number_nxt   = bit_number_r;
    shift_byte_nxt   = shift_byte_r;
    clk_pin_nxt      = clk_pin_r;
    dio_pin_nxt      = dio_pin_r;
    frame_active_nxt = frame_active_r;
    done             = 1'b0;
    nack             = 1'b0;

    if (!frame_active_r) begin
      if (stage.item.start_frame) begin
        frame_active_nxt = 1'b1;
        byte_number_nxt  = ldsw_pkg::BYTE_DATA_CMD;
        bit_number_nxt   = 3'd0;
        shift_byte_nxt   = regs.data_command;
        clk_pin_nxt      = 1'b1;
        dio_pin_nxt      = 1'b0;
        phase_nxt        = ldsw_pkg::PH_BITLO;
      end
    end else begin
      unique case (phase_r)
        ldsw_pkg::PH_START: begin
          dio_pin_nxt    = 1'b0;
          bit_number_nxt = 3'd0;
          shift_byte_nxt = sel_value;
          phase_nxt      = ldsw_pkg::PH_BITLO;
        end
        ldsw_pkg::PH_BITLO: begin
          clk_pin_nxt = 1'b0;
          dio_pin_nxt = shift_byte_r[0];
          phase_nxt   = ldsw_pkg::PH_BITHI;
        end
        ldsw_pkg::PH_BITHI: begin
          clk_pin_nxt    = 1'b1;
          shift_byte_nxt = {1'b0, shift_byte_r[7:1]};
          if (bit_number_r == ldsw_pkg::LAST_BIT) begin
            bit_number_nxt = 3'd0;
            phase_nxt      = ldsw_pkg::PH_ACKLO;
          end else begin
            bit_number_nxt = bit_number_r + 3'd1;
            phase_nxt      = ldsw_pkg::PH_BITLO;
          end
        end
        ldsw_pkg::PH_ACKLO: begin
          clk_pin_nxt = 1'b0;
          dio_pin_nxt = 1'b1;
          phase_nxt   = ldsw_pkg::PH_ACKSMP;
        end
        ldsw_pkg::PH_ACKSMP: begin
          clk_pin_nxt = 1'b1;
          if (ack) begin
            // Device did not acknowledge: release both lines and abort
            dio_pin_nxt      = 1'b1;
            frame_active_nxt = 1'b0;
            phase_nxt        = ldsw_pkg::PH_START;
            byte_number_nxt  = 3'd0;
            bit_number_nxt   = 3'd0;
            nack             = 1'b1;
          end else begin
            byte_number_nxt = byte_number_r + 3'd1;
            // Address command and first three digits run on; other bytes end in a stop
            if (byte_number_r == ldsw_pkg::BYTE_DATA_CMD ||
                byte_number_r >= ldsw_pkg::BYTE_DIGIT3) begin
              phase_nxt = ldsw_pkg::PH_STOP0;
            end else begin
              shift_byte_nxt = sel_value;
              bit_number_nxt = 3'd0;
              phase_nxt      = ldsw_pkg::PH_BITLO;
            end
          end
        end
        ldsw_pkg::PH_STOP0: begin
          clk_pin_nxt = 1'b0;
          dio_pin_nxt = 1'b0;
          phase_nxt   = ldsw_pkg::PH_STOP1;
        end
        ldsw_pkg::PH_STOP1: begin
          clk_pin_nxt = 1'b1;
          phase_nxt   = ldsw_pkg::PH_STOP2;
        end
        ldsw_pkg::PH_STOP2: begin
          dio_pin_nxt = 1'b1;
          phase_nxt   = ldsw_pkg::PH_START;
          if (byte_number_r == ldsw_pkg::BYTE_END) begin
            frame_active_nxt = 1'b0;
            byte_number_nxt  = 3'd0;
            done             = 1'b1;
          end
        end
        default: begin
          phase_nxt = ldsw_pkg::PH_START;
        end
      endcase
    end
  end

  // Sequencer state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r        <= ldsw_pkg::PH_START;
      byte_number_r  <= 3'd0;
      bit_number_r   <= 3'd0;
      shift_byte_r   <= 8'h00;
      clk_pin_r      <= 1'b1;
      dio_pin_r      <= 1'b1;
      frame_active_r <= 1'b0;
    end else if (fire) begin
      phase_r        <= phase_nxt;
      byte_number_r  <= byte_number_nxt;
      bit_number_r   <= bit_number_nxt;
      shift_byte_r   <= shift_byte_nxt;
      clk_pin_r      <= clk_pin_nxt;
      dio_pin_r      <= dio_pin_nxt;
      frame_active_r <= frame_active_nxt;
    end
  end

  // Digit glyphs latched at frame start
  always_ff @(posedge clk) begin
    if (load_digits) begin
      segment_latch_r[0] <= ldsw_pkg::glyph(stage.item.hours_bcd[7:4]);
      segment_latch_r[1] <= ldsw_pkg::glyph(stage.item.hours_bcd[3:0]) |
                            (stage.item.colon_on ? ldsw_pkg::COLON_MASK : 8'h00);
      segment_latch_r[2] <= ldsw_pkg::glyph(stage.item.minutes_bcd[7:4]);
      segment_latch_r[3] <= ldsw_pkg::glyph(stage.item.minutes_bcd[3:0]);
    end
  end

  // Result register
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (fire) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_clk_r  <= clk_pin_nxt;
      out_dio_r  <= dio_pin_nxt;
      out_busy_r <= frame_active_nxt;
      out_done_r <= done;
      out_nack_r <= nack;
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.clk_level  = out_clk_r;
  assign out_ch.dio_level  = out_dio_r;
  assign out_ch.busy_res   = out_busy_r;
  assign out_ch.frame_done = out_done_r;
  assign out_ch.nack_error = out_nack_r;

`ifndef ASSERT_OFF
  // An idle sequencer always waits in the start phase
  a_idle_phase: assert property (@(posedge clk) disable iff (!rst_n)
    !frame_active_r |-> phase_r == ldsw_pkg::PH_START)
    else $error("idle sequencer not in start phase");

  // An abort result releases both lines and shows the block idle
  a_nack_release: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_nack_r |-> !out_busy_r && out_clk_r && out_dio_r)
    else $error("abort result without released lines");

  // A finished frame ends idle with both lines high
  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_done_r |-> !out_busy_r && out_clk_r && out_dio_r && !out_nack_r)
    else $error("frame done with bad line state");

  // Bit counting only happens inside a byte transfer
  a_bit_count: assert property (@(posedge clk) disable iff (!rst_n)
    bit_number_r != 3'd0 |->
      phase_r == ldsw_pkg::PH_BITLO || phase_r == ldsw_pkg::PH_BITHI)
    else $error("bit counter active outside a byte");

  // The end marker is only reached during the final stop
  a_end_in_stop: assert property (@(posedge clk) disable iff (!rst_n)
    byte_number_r == ldsw_pkg::BYTE_END |->
      phase_r == ldsw_pkg::PH_STOP0 || phase_r == ldsw_pkg::PH_STOP1 ||
      phase_r == ldsw_pkg::PH_STOP2)
    else $error("end marker outside final stop");
`endif

endmodule

`default_nettype wire

@@ src/led_digit_serial_writer_unit.sv @@
// Top level of the two-wire LED digit writer.
// Depends on ldsw_pkg, the channel interfaces, ldsw_cfg_regs, ldsw_in_stage
// and ldsw_frame_seq.
//
//   Channel   Dir   Handshake        Payload
//   in_ch     in    valid / ready    start_frame, hours_bcd, minutes_bcd,
//                                    colon_on, dio_sample
//   out_ch    out   valid / ready    clk_level, dio_level, busy_res,
//                                    frame_done, nack_error
//   cfg_ch    in    valid / ready    addr (register index), data
//
// One tick per cycle sustained while the output is not stalled; each tick
// passes the input register, then the sequencer into the result register.
// Reset (rst_n low, synchronous) idles the sequencer with both lines high and
// loads the default command bytes. A stalled output holds the input register;
// one more tick is still accepted while a result waits. cfg_ch is always ready.
`default_nettype none

module led_digit_serial_writer_unit (
  input  wire logic   clk,
  input  wire logic   rst_n,
  ldsw_in_if.sink     in_ch,
  ldsw_out_if.source  out_ch,
  ldsw_cfg_if.sink    cfg_ch
);

  ldsw_pkg::cfg_regs_t regs;
  ldsw_pkg::stage_t    stage;
  logic                advance;

  ldsw_cfg_regs u_cfg (
    .clk   (clk),
    .rst_n (rst_n),
    .cfg   (cfg_ch),
    .regs  (regs)
  );

  ldsw_in_stage u_in (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .advance (advance),
    .stage   (stage)
  );

  ldsw_frame_seq u_seq (
    .clk     (clk),
    .rst_n   (rst_n),
    .stage   (stage),
    .regs    (regs),
    .advance (advance),
    .out_ch  (out_ch)
  );

endmodule

`default_nettype wire

@@ verif/ldsw_frame_checker.sv @@
// Scoreboard for the two-wire LED digit writer: a tick-by-tick model of the
// frame sequencer that predicts each result transaction and compares it.
// Depends on ldsw_pkg and the channel interfaces of ldsw_ifs.sv.

module ldsw_frame_checker
  import ldsw_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  ldsw_in_if          in_ch,
  ldsw_out_if         out_ch,
  ldsw_cfg_if         cfg_ch,
  output int unsigned mismatches,
  output int unsigned pending,
  output int unsigned ticks_checked,
  output int unsigned frames_done,
  output int unsigned frames_nacked
);

  // Pin levels and status after one tick
  typedef struct packed {
    logic clk_level;
    logic dio_level;
    logic busy_res;
    logic frame_done;
    logic nack_error;
  } pins_t;

  // Command bytes as last written
  logic [7:0] cmd_data;
  logic [7:0] cmd_addr;
  logic [7:0] cmd_disp;

  // Sequencer mirror
  phase_t     phase;
  logic [2:0] byte_no;
  logic [2:0] bit_no;
  logic [7:0] shreg;
  logic [7:0] digit_seg [4];
  logic       clk_q;
  logic       dio_q;
  logic       active;

  pins_t pin_levels_due [$];

  // Segment pattern of one BCD digit; non-decimal nibbles go dark
  function automatic logic [7:0] seg_font(input logic [3:0] nib);
    case (nib)
      4'd0:    return 8'h3f;
      4'd1:    return 8'h06;
      4'd2:    return 8'h5b;
      4'd3:    return 8'h4f;
      4'd4:    return 8'h66;
      4'd5:    return 8'h6d;
      4'd6:    return 8'h7d;
      4'd7:    return 8'h07;
      4'd8:    return 8'h7f;
      4'd9:    return 8'h6f;
      default: return 8'h00;
    endcase
  endfunction

  // Byte sent in slot n of the frame
  function automatic logic [7:0] frame_byte(input logic [2:0] n);
    case (n)
      BYTE_DATA_CMD: return cmd_data;
      BYTE_ADDR_CMD: return cmd_addr;
      BYTE_DIGIT0, BYTE_DIGIT1, BYTE_DIGIT2, BYTE_DIGIT3:
        return digit_seg[2'(n - BYTE_DIGIT0)];
      BYTE_DISP_CTL: return cmd_disp;
      default:       return 8'h00;
    endcase
  endfunction

  task automatic reset_model();
    cmd_data = DATA_CMD_RST;
    cmd_addr = ADDR_CMD_RST;
    cmd_disp = DISP_CTL_RST;
    phase    = PH_START;
    byte_no  = BYTE_DATA_CMD;
    bit_no   = '0;
    shreg    = '0;
    for (int i = 0; i < 4; i++) digit_seg[i] = '0;
    clk_q    = 1'b1;
    dio_q    = 1'b1;
    active   = 1'b0;
  endtask

  // Advance the sequencer by one tick and return the pin levels after it
  task automatic next_pin_levels(input in_item_t it, output pins_t res);
    logic [2:0] nxt;
    res = '0;
    if (!active) begin
      // idle: only a start request does anything
      if (it.start_frame) begin
        digit_seg[0] = seg_font(it.hours_bcd[7:4]);
        digit_seg[1] = seg_font(it.hours_bcd[3:0]) | (it.colon_on ? COLON_MASK : 8'h00);
        digit_seg[2] = seg_font(it.minutes_bcd[7:4]);
        digit_seg[3] = seg_font(it.minutes_bcd[3:0]);
        active  = 1'b1;
        byte_no = BYTE_DATA_CMD;
        bit_no  = '0;
        shreg   = frame_byte(BYTE_DATA_CMD);
        clk_q   = 1'b1;
        dio_q   = 1'b0;
        phase   = PH_BITLO;
      end
    end else begin
      case (phase)
        PH_START: begin
          dio_q  = 1'b0;
          bit_no = '0;
          shreg  = frame_byte(byte_no);
          phase  = PH_BITLO;
        end
        PH_BITLO: begin
          clk_q = 1'b0;
          dio_q = shreg[0];
          phase = PH_BITHI;
        end
        PH_BITHI: begin
          clk_q = 1'b1;
          shreg = shreg >> 1;
          if (bit_no == LAST_BIT) begin
            bit_no = '0;
            phase  = PH_ACKLO;
          end else begin
            bit_no = bit_no + 3'd1;
            phase  = PH_BITLO;
          end
        end
        PH_ACKLO: begin
          clk_q = 1'b0;
          dio_q = 1'b1;
          phase = PH_ACKSMP;
        end
        PH_ACKSMP: begin
          if (it.dio_sample) begin
            // no acknowledge: drop the frame, release both lines
            clk_q   = 1'b1;
            dio_q   = 1'b1;
            active  = 1'b0;
            phase   = PH_START;
            byte_no = BYTE_DATA_CMD;
            bit_no  = '0;
            res.nack_error = 1'b1;
          end else begin
            clk_q = 1'b1;
            nxt   = byte_no + 3'd1;
            // stop after each command group, digit bytes run back to back
            if (byte_no == BYTE_DATA_CMD || byte_no >= BYTE_DIGIT3) begin
              phase = PH_STOP0;
            end else begin
              shreg  = frame_byte(nxt);
              bit_no = '0;
              phase  = PH_BITLO;
            end
            byte_no = nxt;
          end
        end
        PH_STOP0: begin
          clk_q = 1'b0;
          dio_q = 1'b0;
          phase = PH_STOP1;
        end
        PH_STOP1: begin
          clk_q = 1'b1;
          phase = PH_STOP2;
        end
        default: begin
          dio_q = 1'b1;
          phase = PH_START;
          if (byte_no == BYTE_END) begin
            active  = 1'b0;
            byte_no = BYTE_DATA_CMD;
            res.frame_done = 1'b1;
          end
        end
      endcase
    end
    res.clk_level = clk_q;
    res.dio_level = dio_q;
    res.busy_res  = active;
  endtask

  task automatic compare_field(input string field, input logic want, input logic got);
    if (got !== want) begin
      $error("%s: expected %0b, got %0b", field, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    in_item_t it;
    pins_t    want;
    pins_t    got;
    if (!rst_n) begin
      reset_model();
      pin_levels_due.delete();
      mismatches    = 0;
      pending       = 0;
      ticks_checked = 0;
      frames_done   = 0;
      frames_nacked = 0;
    end else begin
      // results first: nothing accepted at this edge can have come out yet
      if (out_ch.valid && out_ch.ready) begin
        got.clk_level  = out_ch.clk_level;
        got.dio_level  = out_ch.dio_level;
        got.busy_res   = out_ch.busy_res;
        got.frame_done = out_ch.frame_done;
        got.nack_error = out_ch.nack_error;
        if (pin_levels_due.size() == 0) begin
          $error("result transaction with no tick outstanding");
          mismatches++;
        end else begin
          want = pin_levels_due.pop_front();
          compare_field("clk_level", want.clk_level, got.clk_level);
          compare_field("dio_level", want.dio_level, got.dio_level);
          compare_field("busy_res", want.busy_res, got.busy_res);
          compare_field("frame_done", want.frame_done, got.frame_done);
          compare_field("nack_error", want.nack_error, got.nack_error);
          ticks_checked++;
        end
      end

      // register writes; the unused index is dropped
      if (cfg_ch.valid && cfg_ch.ready) begin
        case (cfg_ch.addr)
          REG_DATA_CMD: cmd_data = cfg_ch.data;
          REG_ADDR_CMD: cmd_addr = cfg_ch.data;
          REG_DISP_CTL: cmd_disp = cfg_ch.data;
          default: ;
        endcase
      end

      // accepted tick
      if (in_ch.valid && in_ch.ready) begin
        it.start_frame = in_ch.start_frame;
        it.hours_bcd   = in_ch.hours_bcd;
        it.minutes_bcd = in_ch.minutes_bcd;
        it.colon_on    = in_ch.colon_on;
        it.dio_sample  = in_ch.dio_sample;
        next_pin_levels(it, want);
        pin_levels_due.push_back(want);
        if (want.frame_done) frames_done++;
        if (want.nack_error) frames_nacked++;
      end
      pending = pin_levels_due.size();
    end
  end

endmodule

@@ verif/tb.sv @@
// Testbench top for led_digit_serial_writer_unit: drives display frames,
// command-byte settings and back-pressure; ldsw_frame_checker does the checking.
// Depends on ldsw_pkg, ldsw_ifs.sv, the RTL and ldsw_frame_checker.

module tb;

  // Tick offsets within a frame, counted from the start tick
  localparam int FRAME_TICKS   = 138;
  localparam int DATA_ACK_TICK = 18;
  localparam int ADDR_ACK_TICK = 40;
  localparam int BYTE_TICKS    = 18;
  localparam int DISP_ACK_TICK = 134;
  localparam int STOP_TICKS    = 3;
  localparam int NO_NACK       = -1;

  localparam logic [ldsw_pkg::CfgAddrW-1:0] REG_UNUSED = 2'd3;

  localparam int RANDOM_ITEMS     = 480;
  localparam int CALM_ITEMS       = 200;
  localparam int LONG_HOLD_CYCLES = 150;
  localparam int DRAIN_CYCLES     = 6;
  localparam int CYCLE_LIMIT      = 300000;

  logic clk;
  logic rst_n;

  ldsw_in_if  in_ch ();
  ldsw_out_if out_ch ();
  ldsw_cfg_if cfg_ch ();

  int unsigned mismatches;
  int unsigned pending;
  int unsigned ticks_checked;
  int unsigned frames_done;
  int unsigned frames_nacked;

  led_digit_serial_writer_unit i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  ldsw_frame_checker i_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_ch         (in_ch),
    .out_ch        (out_ch),
    .cfg_ch        (cfg_ch),
    .mismatches    (mismatches),
    .pending       (pending),
    .ticks_checked (ticks_checked),
    .frames_done   (frames_done),
    .frames_nacked (frames_nacked)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Shared control between stimulus and the result sink
  bit calm;
  bit long_hold;
  int src_quiet;
  int items_sent;
  int cfg_writes;

  // Frame being sent
  logic [7:0] fr_hours;
  logic [7:0] fr_minutes;
  logic       fr_colon;
  int         fr_nack_byte;

  logic [7:0] cur_data_cmd;
  logic [7:0] cur_addr_cmd;
  logic [7:0] cur_disp_ctl;

  // Tick at which the ACK of frame byte b is sampled
  function automatic int ack_tick(input int b);
    if (b == ldsw_pkg::BYTE_DATA_CMD) return DATA_ACK_TICK;
    if (b == ldsw_pkg::BYTE_DISP_CTL) return DISP_ACK_TICK;
    return ADDR_ACK_TICK + (b - ldsw_pkg::BYTE_ADDR_CMD) * BYTE_TICKS;
  endfunction

  function automatic int ack_owner(input int k);
    for (int b = ldsw_pkg::BYTE_DATA_CMD; b <= ldsw_pkg::BYTE_DISP_CTL; b++) begin
      if (ack_tick(b) == k) return b;
    end
    return NO_NACK;
  endfunction

  // Mostly well-formed BCD, now and then any byte
  function automatic logic [7:0] rand_bcd();
    if ($urandom_range(0, 3) == 0) return 8'($urandom);
    return {4'($urandom_range(0, 9)), 4'($urandom_range(0, 9))};
  endfunction

  // One input transaction, with random source-side gaps
  task automatic send_tick(input ldsw_pkg::in_item_t it);
    if (!calm && src_quiet == 0 && $urandom_range(0, 5) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
    if (src_quiet > 0) src_quiet--;
    else if ($urandom_range(0, 49) == 0) src_quiet = $urandom_range(20, 120);
    in_ch.valid       <= 1'b1;
    in_ch.start_frame <= it.start_frame;
    in_ch.hours_bcd   <= it.hours_bcd;
    in_ch.minutes_bcd <= it.minutes_bcd;
    in_ch.colon_on    <= it.colon_on;
    in_ch.dio_sample  <= it.dio_sample;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  // Ticks first..last of the current frame; ACK slots are low except the
  // one chosen to fail, every other tick carries random noise
  task automatic send_frame_ticks(input int first, input int last);
    ldsw_pkg::in_item_t it;
    int                 owner;
    for (int k = first; k <= last; k++) begin
      it.start_frame = (k == 0) ? 1'b1 : 1'($urandom_range(0, 1));
      it.hours_bcd   = (k == 0) ? fr_hours : 8'($urandom);
      it.minutes_bcd = (k == 0) ? fr_minutes : 8'($urandom);
      it.colon_on    = (k == 0) ? fr_colon : 1'($urandom_range(0, 1));
      owner          = ack_owner(k);
      if (owner == NO_NACK) it.dio_sample = 1'($urandom_range(0, 1));
      else                  it.dio_sample = (owner == fr_nack_byte);
      send_tick(it);
      items_sent++;
    end
  endtask

  task automatic send_idle_tick();
    ldsw_pkg::in_item_t it;
    it.start_frame = 1'b0;
    it.hours_bcd   = 8'($urandom);
    it.minutes_bcd = 8'($urandom);
    it.colon_on    = 1'($urandom_range(0, 1));
    it.dio_sample  = 1'($urandom_range(0, 1));
    send_tick(it);
  endtask

  // Stop offering ticks and wait for every result to come back
  task automatic drain();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    wait (pending == 0);
  endtask

  task automatic write_reg(input logic [ldsw_pkg::CfgAddrW-1:0] idx, input logic [7:0] val);
    cfg_ch.valid <= 1'b1;
    cfg_ch.addr  <= idx;
    cfg_ch.data  <= val;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_writes++;
  endtask

  // Only called with no tick in flight
  task automatic program_regs(input logic [7:0] d, input logic [7:0] a, input logic [7:0] c);
    write_reg(ldsw_pkg::REG_DATA_CMD, d);
    write_reg(ldsw_pkg::REG_ADDR_CMD, a);
    write_reg(ldsw_pkg::REG_DISP_CTL, c);
    write_reg(REG_UNUSED, 8'($urandom));
    cfg_ch.valid <= 1'b0;
    cur_data_cmd = d;
    cur_addr_cmd = a;
    cur_disp_ctl = c;
  endtask

  task automatic set_frame(input logic [7:0] h, input logic [7:0] m, input logic col,
                           input int nack_byte);
    fr_hours     = h;
    fr_minutes   = m;
    fr_colon     = col;
    fr_nack_byte = nack_byte;
  endtask

  function automatic int frame_last_tick();
    return (fr_nack_byte == NO_NACK) ? FRAME_TICKS - 1 : ack_tick(fr_nack_byte);
  endfunction

  // Result sink: random stall bursts, quiet stretches, up to two long hold-offs
  initial begin : result_sink
    int quiet;
    quiet = 0;
    out_ch.ready <= 1'b1;
    forever begin
      @(posedge clk);
      if (long_hold) begin
        out_ch.ready <= 1'b0;
        repeat (LONG_HOLD_CYCLES) @(posedge clk);
        long_hold = 1'b0;
        out_ch.ready <= 1'b1;
      end else if (!calm && quiet == 0 && $urandom_range(0, 7) == 0) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 10)) @(posedge clk);
        out_ch.ready <= 1'b1;
      end else begin
        if (quiet > 0) quiet--;
        else if ($urandom_range(0, 63) == 0) quiet = $urandom_range(30, 150);
        out_ch.ready <= 1'b1;
      end
    end
  end

  initial begin : watchdog
    int unsigned cycle_count;
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("FAIL led_digit_serial_writer_unit");
    $finish;
  end

  // Stimulus and verdict
  initial begin : stimulus
    int last;
    int target;
    calm       = 1'b0;
    long_hold  = 1'b0;
    src_quiet  = 0;
    items_sent = 0;
    cfg_writes = 0;
    cur_data_cmd = ldsw_pkg::DATA_CMD_RST;
    cur_addr_cmd = ldsw_pkg::ADDR_CMD_RST;
    cur_disp_ctl = ldsw_pkg::DISP_CTL_RST;

    rst_n              <= 1'b0;
    in_ch.valid        <= 1'b0;
    in_ch.start_frame  <= 1'b0;
    in_ch.hours_bcd    <= '0;
    in_ch.minutes_bcd  <= '0;
    in_ch.colon_on     <= 1'b0;
    in_ch.dio_sample   <= 1'b0;
    cfg_ch.valid       <= 1'b0;
    cfg_ch.addr        <= '0;
    cfg_ch.data        <= '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Full frame with the command bytes out of reset, digits 0..3, colon lit
    set_frame(8'h01, 8'h23, 1'b1, NO_NACK);
    send_frame_ticks(0, frame_last_tick());

    // All-ones commands; address and display bytes rewritten mid-frame,
    // after the data command has gone out; digits 4..7, NACK on the last digit
    drain();
    program_regs(8'hFF, 8'hFF, 8'hFF);
    set_frame(8'h45, 8'h67, 1'b0, ldsw_pkg::BYTE_DIGIT3);
    send_frame_ticks(0, DATA_ACK_TICK + STOP_TICKS);
    drain();
    program_regs(cur_data_cmd, 8'h00, 8'h00);
    send_frame_ticks(DATA_ACK_TICK + STOP_TICKS + 1, frame_last_tick());

    // Digits 8, 9 and blanked nibbles; NACK on the display control byte
    set_frame(8'h89, 8'hFC, 1'b1, ldsw_pkg::BYTE_DISP_CTL);
    send_frame_ticks(0, frame_last_tick());

    // Field extremes, NACK on the very first ACK
    set_frame(8'hFF, 8'h00, 1'b0, ldsw_pkg::BYTE_DATA_CMD);
    send_frame_ticks(0, frame_last_tick());
    send_idle_tick();

    // Random frames under rotating command settings
    target = items_sent + RANDOM_ITEMS;
    for (int f = 0; items_sent < target; f++) begin
      if (f % 2 == 0) begin
        drain();
        case ((f / 2) % 4)
          0:       program_regs(8'h00, 8'h00, 8'h00);
          1:       program_regs(8'hFF, 8'hFF, 8'hFF);
          2:       program_regs(8'($urandom), 8'($urandom), 8'($urandom));
          default: program_regs(ldsw_pkg::DATA_CMD_RST, ldsw_pkg::ADDR_CMD_RST,
                                ldsw_pkg::DISP_CTL_RST);
        endcase
      end
      if (items_sent >= target - CALM_ITEMS) calm = 1'b1;
      // block the result side for a long while so the input backs up
      if (!calm && (f == 1 || f == 6)) long_hold = 1'b1;

      set_frame(rand_bcd(), rand_bcd(), 1'($urandom_range(0, 1)),
                ($urandom_range(0, 4) < 2) ?
                  int'($urandom_range(ldsw_pkg::BYTE_DATA_CMD, ldsw_pkg::BYTE_DISP_CTL))
                  : NO_NACK);
      last = frame_last_tick();
      // now and then a frame is cut off partway
      if ($urandom_range(0, 9) == 0) last = $urandom_range(1, last);
      send_frame_ticks(0, last);
      repeat ($urandom_range(0, 2)) send_idle_tick();
    end

    drain();
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Checked %0d ticks: %0d frames completed, %0d aborted on a high ACK,",
             ticks_checked, frames_done, frames_nacked);
    $display("%0d register writes over several command-byte settings", cfg_writes);
    if (mismatches == 0 && pending == 0) begin
      $display("PASS led_digit_serial_writer_unit");
    end else begin
      $display("FAIL led_digit_serial_writer_unit");
    end
    $finish;
  end

endmodule
